@@ design/orn_pkg.sv @@
// Shared types and constants for the occupancy relay node controller.
`timescale 1ns / 1ps
package orn_pkg;

  localparam int unsigned NODE_W    = 8;
  localparam int unsigned PERIOD_W  = 10;
  localparam int unsigned TPS_W     = 7;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned ABSENCE_W = 14;
  localparam int unsigned CODE_W    = 6;
  localparam int unsigned RELAY_N   = 4;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [NODE_W-1:0]    NODE_ID_RST      = 8'd52;
  localparam logic [PERIOD_W-1:0]  REPORT_PERIOD_RST = 10'd600;
  localparam logic [TPS_W-1:0]     TICKS_PER_SEC_RST = 7'd100;
  localparam logic [DELAY_W-1:0]   INIT_DELAY_RST    = 8'd10;
  localparam logic [ABSENCE_W-1:0] SECONDS_PER_MINUTE = 14'd60;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_SENSOR  = 2'd1;
  localparam logic [1:0] KIND_COMMAND = 2'd2;

  localparam logic [7:0] CMD_SET_SILENT = 8'd20;
  localparam logic [7:0] CMD_SET_REPLY  = 8'd22;
  localparam logic [7:0] CMD_STATUS     = 8'd50;

  localparam logic [CODE_W-1:0] CODE_PERIODIC     = 6'd1;
  localparam logic [CODE_W-1:0] CODE_OCCUPANCY    = 6'd2;
  localparam logic [CODE_W-1:0] CODE_CMD_REPLY    = 6'd23;
  localparam logic [CODE_W-1:0] CODE_STATUS_REPLY = 6'd51;

  typedef enum logic [1:0] {
    REG_NODE_ID       = 2'd0,
    REG_REPORT_PERIOD = 2'd1,
    REG_TICKS_PER_SEC = 2'd2,
    REG_INIT_DELAY    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node_id;
    logic [PERIOD_W-1:0] report_period;
    logic [TPS_W-1:0]    ticks_per_second;
    logic [DELAY_W-1:0]  initial_delay;
    logic                delay_load;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               sensor_level;
    logic [7:0]         command_code;
    logic [7:0]         relay_one_request;
    logic [7:0]         relay_two_request;
    logic [7:0]         relay_three_request;
    logic [7:0]         relay_four_request;
    logic [DELAY_W-1:0] new_delay_minutes;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic               report_valid;
    logic [CODE_W-1:0]  report_code;
    logic [NODE_W-1:0]  report_node;
    logic               relay_one_on;
    logic               relay_two_on;
    logic               relay_three_on;
    logic               relay_four_on;
    logic               sensor_now;
    logic               occupied;
    logic [DELAY_W-1:0] delay_now;
    logic               save_delay;
  } result_t;

endpackage

@@ design/orn_if.sv @@
// Input and result channel interfaces of the occupancy relay node controller.
`timescale 1ns / 1ps
interface orn_in_if;
  import orn_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               sensor_level;
  logic [7:0]         command_code;
  logic [7:0]         relay_one_request;
  logic [7:0]         relay_two_request;
  logic [7:0]         relay_three_request;
  logic [7:0]         relay_four_request;
  logic [DELAY_W-1:0] new_delay_minutes;

  modport source (
    output valid, kind, sensor_level, command_code, relay_one_request,
           relay_two_request, relay_three_request, relay_four_request,
           new_delay_minutes,
    input  ready
  );
  modport sink (
    input  valid, kind, sensor_level, command_code, relay_one_request,
           relay_two_request, relay_three_request, relay_four_request,
           new_delay_minutes,
    output ready
  );
endinterface

interface orn_out_if;
  import orn_pkg::*;
  logic               valid;
  logic               ready;
  logic               report_valid;
  logic [CODE_W-1:0]  report_code;
  logic [NODE_W-1:0]  report_node;
  logic               relay_one_on;
  logic               relay_two_on;
  logic               relay_three_on;
  logic               relay_four_on;
  logic               sensor_now;
  logic               occupied;
  logic [DELAY_W-1:0] delay_now;
  logic               save_delay;

  modport source (
    output valid, report_valid, report_code, report_node, relay_one_on,
           relay_two_on, relay_three_on, relay_four_on, sensor_now, occupied,
           delay_now, save_delay,
    input  ready
  );
  modport sink (
    input  valid, report_valid, report_code, report_node, relay_one_on,
           relay_two_on, relay_three_on, relay_four_on, sensor_now, occupied,
           delay_now, save_delay,
    output ready
  );
endinterface

@@ design/orn_cfg.sv @@
// APB configuration registers of the occupancy relay node controller.
`timescale 1ns / 1ps
module orn_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [orn_pkg::APB_AW-1:0] paddr,
  input  logic [orn_pkg::APB_DW-1:0] pwdata,
  output logic [orn_pkg::APB_DW-1:0] prdata,
  output logic                   pready,
  output orn_pkg::cfg_t          cfg
);
  import orn_pkg::*;

  logic [NODE_W-1:0]   node_id;
  logic [PERIOD_W-1:0] report_period;
  logic [TPS_W-1:0]    ticks_per_second;
  logic [DELAY_W-1:0]  initial_delay;
  logic                wr_en;
  reg_index_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id          <= NODE_ID_RST;
      report_period    <= REPORT_PERIOD_RST;
      ticks_per_second <= TICKS_PER_SEC_RST;
      initial_delay    <= INIT_DELAY_RST;
    end else if (wr_en) begin
      case (idx)
        REG_NODE_ID:       node_id          <= pwdata[NODE_W-1:0];
        REG_REPORT_PERIOD: report_period    <= pwdata[PERIOD_W-1:0];
        REG_TICKS_PER_SEC: ticks_per_second <= pwdata[TPS_W-1:0];
        REG_INIT_DELAY:    initial_delay    <= pwdata[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NODE_ID:       prdata = APB_DW'(node_id);
      REG_REPORT_PERIOD: prdata = APB_DW'(report_period);
      REG_TICKS_PER_SEC: prdata = APB_DW'(ticks_per_second);
      REG_INIT_DELAY:    prdata = APB_DW'(initial_delay);
      default:           prdata = '0;
    endcase
  end

  assign cfg.node_id          = node_id;
  assign cfg.report_period    = report_period;
  assign cfg.ticks_per_second = ticks_per_second;
  assign cfg.initial_delay    = pwdata[DELAY_W-1:0];
  assign cfg.delay_load       = wr_en && (idx == REG_INIT_DELAY);

endmodule

@@ design/orn_in_stage.sv @@
// Input register that holds one accepted beat for the step logic.
`timescale 1ns / 1ps
module orn_in_stage (
  input  logic            clk,
  input  logic            rst,
  orn_in_if.sink          in_ch,
  input  logic            advance,
  output orn_pkg::stage_t stage
);
  import orn_pkg::*;

  logic  in_valid;
  item_t item;
  logic  accept;

  assign in_ch.ready = !in_valid || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind                <= in_ch.kind;
      item.sensor_level        <= in_ch.sensor_level;
      item.command_code        <= in_ch.command_code;
      item.relay_one_request   <= in_ch.relay_one_request;
      item.relay_two_request   <= in_ch.relay_two_request;
      item.relay_three_request <= in_ch.relay_three_request;
      item.relay_four_request  <= in_ch.relay_four_request;
      item.new_delay_minutes   <= in_ch.new_delay_minutes;
    end
  end

  assign stage.valid = in_valid;
  assign stage.item  = item;

endmodule

@@ design/orn_engine.sv @@
// Node state, single-pass step logic and result register.
`timescale 1ns / 1ps
module orn_engine (
  input  logic            clk,
  input  logic            rst,
  input  orn_pkg::cfg_t   cfg,
  input  orn_pkg::stage_t stage,
  output logic            advance,
  orn_out_if.source       out_ch
);
  import orn_pkg::*;

  logic [TPS_W-1:0]     tick_divider, tick_divider_next, tick_inc;
  logic [PERIOD_W-1:0]  report_timer, report_timer_next, timer_inc;
  logic [ABSENCE_W-1:0] absence_seconds, absence_seconds_next, absence_inc;
  logic [ABSENCE_W-1:0] delay_limit;
  logic                 absence_running, absence_running_next;
  logic                 room_occupied, room_occupied_next;
  logic                 previous_level, previous_level_next;
  logic [DELAY_W-1:0]   delay_minutes, delay_minutes_next;
  logic [RELAY_N-1:0]   relay_states, relay_states_next;
  logic                 periodic, occ_event, rep_valid, saved, set_cmd;
  logic [CODE_W-1:0]    rep_code;
  logic                 out_valid;
  result_t              result, result_next;
  item_t                it;

  assign it          = stage.item;
  assign advance     = stage.valid && (!out_valid || out_ch.ready);
  assign tick_inc    = tick_divider + 1'b1;
  assign timer_inc   = report_timer + 1'b1;
  assign absence_inc = absence_seconds + 1'b1;
  assign delay_limit = ABSENCE_W'(delay_minutes) * SECONDS_PER_MINUTE;

  always_comb begin
    tick_divider_next    = tick_divider;
    report_timer_next    = report_timer;
    absence_seconds_next = absence_seconds;
    absence_running_next = absence_running;
    room_occupied_next   = room_occupied;
    previous_level_next  = previous_level;
    delay_minutes_next   = delay_minutes;
    relay_states_next    = relay_states;
    periodic             = 1'b0;
    occ_event            = 1'b0;
    rep_valid            = 1'b0;
    rep_code             = '0;
    saved                = 1'b0;
    set_cmd              = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (tick_inc >= cfg.ticks_per_second) begin
          tick_divider_next = '0;
          if (timer_inc >= cfg.report_period) begin
            report_timer_next = '0;
            periodic          = 1'b1;
          end else begin
            report_timer_next = timer_inc;
          end
          if (absence_running) begin
            if (absence_inc >= delay_limit) begin
              absence_running_next = 1'b0;
              absence_seconds_next = '0;
              room_occupied_next   = 1'b0;
              occ_event            = 1'b1;
            end else begin
              absence_seconds_next = absence_inc;
            end
          end
          if (occ_event) begin
            rep_valid = 1'b1;
            rep_code  = CODE_OCCUPANCY;
          end else if (periodic) begin
            rep_valid = 1'b1;
            rep_code  = CODE_PERIODIC;
          end
        end else begin
          tick_divider_next = tick_inc;
        end
      end
      KIND_SENSOR: begin
        if (it.sensor_level != previous_level) begin
          absence_seconds_next = '0;
          previous_level_next  = it.sensor_level;
          if (it.sensor_level) begin
            absence_running_next = 1'b0;
            if (!room_occupied) begin
              room_occupied_next = 1'b1;
              rep_valid          = 1'b1;
              rep_code           = CODE_OCCUPANCY;
            end
          end else begin
            absence_running_next = 1'b1;
          end
        end
      end
      KIND_COMMAND: begin
        if (it.command_code == CMD_SET_REPLY) begin
          set_cmd   = 1'b1;
          rep_valid = 1'b1;
          rep_code  = CODE_CMD_REPLY;
        end else if (it.command_code == CMD_SET_SILENT) begin
          set_cmd = 1'b1;
        end else if (it.command_code == CMD_STATUS) begin
          rep_valid = 1'b1;
          rep_code  = CODE_STATUS_REPLY;
        end
      end
      default: begin
      end
    endcase
    if (set_cmd) begin
      relay_states_next  = {it.relay_four_request != 8'd0,
                            it.relay_three_request != 8'd0,
                            it.relay_two_request != 8'd0,
                            it.relay_one_request != 8'd0};
      delay_minutes_next = it.new_delay_minutes;
      saved              = it.new_delay_minutes != delay_minutes;
    end
    if (rep_valid) begin
      report_timer_next = '0;
    end
  end

  always_comb begin
    result_next.report_valid   = rep_valid;
    result_next.report_code    = rep_code;
    result_next.report_node    = rep_valid ? cfg.node_id : '0;
    result_next.relay_one_on   = relay_states_next[0];
    result_next.relay_two_on   = relay_states_next[1];
    result_next.relay_three_on = relay_states_next[2];
    result_next.relay_four_on  = relay_states_next[3];
    result_next.sensor_now     = previous_level_next;
    result_next.occupied       = room_occupied_next;
    result_next.delay_now      = delay_minutes_next;
    result_next.save_delay     = saved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider    <= '0;
      report_timer    <= '0;
      absence_seconds <= '0;
      absence_running <= 1'b0;
      room_occupied   <= 1'b0;
      previous_level  <= 1'b0;
      delay_minutes   <= INIT_DELAY_RST;
      relay_states    <= '0;
    end else if (cfg.delay_load) begin
      delay_minutes <= cfg.initial_delay;
    end else if (advance) begin
      tick_divider    <= tick_divider_next;
      report_timer    <= report_timer_next;
      absence_seconds <= absence_seconds_next;
      absence_running <= absence_running_next;
      room_occupied   <= room_occupied_next;
      previous_level  <= previous_level_next;
      delay_minutes   <= delay_minutes_next;
      relay_states    <= relay_states_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.report_valid   = result.report_valid;
  assign out_ch.report_code    = result.report_code;
  assign out_ch.report_node    = result.report_node;
  assign out_ch.relay_one_on   = result.relay_one_on;
  assign out_ch.relay_two_on   = result.relay_two_on;
  assign out_ch.relay_three_on = result.relay_three_on;
  assign out_ch.relay_four_on  = result.relay_four_on;
  assign out_ch.sensor_now     = result.sensor_now;
  assign out_ch.occupied       = result.occupied;
  assign out_ch.delay_now      = result.delay_now;
  assign out_ch.save_delay     = result.save_delay;

endmodule

@@ design/occupancy_relay_node_controller_top.sv @@
// Top level of the occupancy relay node controller.
// An accepted beat waits in the input register; its result goes to the result register.
// Throughput: one beat per cycle while the result channel is not stalled;
// the step logic between the two registers updates all node state in a single pass.
// Reset (synchronous, rst high): channels empty, counters and flags cleared, relays off,
// registers at their defaults and the absence delay loaded from the initial delay.
`timescale 1ns / 1ps
module occupancy_relay_node_controller_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [orn_pkg::APB_AW-1:0] paddr,
  input  logic [orn_pkg::APB_DW-1:0] pwdata,
  output logic [orn_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  orn_in_if.sink                     in_ch,
  orn_out_if.source                  out_ch
);
  import orn_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  orn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  orn_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  orn_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .stage   (stage),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

@@ design/orn_checker.sv @@
// Port-level checks of the occupancy relay node controller and their binding.
`timescale 1ns / 1ps
module orn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       report_valid,
  input logic [orn_pkg::CODE_W-1:0] report_code,
  input logic [orn_pkg::NODE_W-1:0] report_node,
  input logic                       save_delay
);
  import orn_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result beat dropped");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |-> report_code == '0 && report_node == '0)
    else $error("report fields set without a report");

  a_code_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |->
      report_code == CODE_PERIODIC || report_code == CODE_OCCUPANCY ||
      report_code == CODE_CMD_REPLY || report_code == CODE_STATUS_REPLY)
    else $error("unknown report code");

  a_save_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && save_delay && report_valid |-> report_code == CODE_CMD_REPLY)
    else $error("delay saved with a report other than a command reply");

endmodule

bind occupancy_relay_node_controller_top orn_checker u_orn_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .report_valid (out_ch.report_valid),
  .report_code  (out_ch.report_code),
  .report_node  (out_ch.report_node),
  .save_delay   (out_ch.save_delay)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench: directed and random beats, APB setup, predicted status check.
`timescale 1ns / 1ps
module testbench;
  import orn_pkg::*;

  localparam logic [1:0] KIND_UNUSED      = 2'd3;
  localparam logic [7:0] CMD_UNKNOWN_LOW  = 8'd0;
  localparam logic [7:0] CMD_UNKNOWN_NEAR = 8'd21;
  localparam logic [7:0] CMD_UNKNOWN_HIGH = 8'd255;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 60;

  class relay_node_board;
    logic [NODE_W-1:0]    node_id;
    logic [PERIOD_W-1:0]  period_s;
    logic [TPS_W-1:0]     ticks_per_s;
    logic [TPS_W-1:0]     tick_count;
    logic [PERIOD_W-1:0]  seconds_since_report;
    logic [ABSENCE_W-1:0] absent_seconds;
    bit                   absence_on;
    bit                   room_busy;
    bit                   level_seen;
    logic [DELAY_W-1:0]   delay_min;
    logic [RELAY_N-1:0]   relays;
    result_t              status_queue[$];
    int                   fault_count;

    function new();
      node_id = NODE_ID_RST;
      period_s = REPORT_PERIOD_RST;
      ticks_per_s = TICKS_PER_SEC_RST;
      delay_min = INIT_DELAY_RST;
      tick_count = '0;
      seconds_since_report = '0;
      absent_seconds = '0;
      absence_on = 1'b0;
      room_busy = 1'b0;
      level_seen = 1'b0;
      relays = '0;
      fault_count = 0;
    endfunction

    function void write_register(reg_index_t idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_NODE_ID:       node_id = value[NODE_W-1:0];
        REG_REPORT_PERIOD: period_s = value[PERIOD_W-1:0];
        REG_TICKS_PER_SEC: ticks_per_s = value[TPS_W-1:0];
        REG_INIT_DELAY:    delay_min = value[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(item_t it);
      result_t           r;
      bit                periodic;
      bit                vacated;
      bit                issue;
      bit                saved;
      logic [CODE_W-1:0] code;
      r = '0;
      periodic = 1'b0;
      vacated = 1'b0;
      issue = 1'b0;
      saved = 1'b0;
      code = '0;
      case (it.kind)
        KIND_TICK: begin
          tick_count = tick_count + 1'b1;
          if (tick_count >= ticks_per_s) begin
            tick_count = '0;
            seconds_since_report = seconds_since_report + 1'b1;
            if (seconds_since_report >= period_s) begin
              seconds_since_report = '0;
              periodic = 1'b1;
            end
            if (absence_on) begin
              absent_seconds = absent_seconds + 1'b1;
              if (int'(absent_seconds) >= int'(delay_min) * int'(SECONDS_PER_MINUTE)) begin
                absence_on = 1'b0;
                absent_seconds = '0;
                room_busy = 1'b0;
                vacated = 1'b1;
              end
            end
            if (vacated) begin
              issue = 1'b1;
              code = CODE_OCCUPANCY;
            end else if (periodic) begin
              issue = 1'b1;
              code = CODE_PERIODIC;
            end
          end
        end
        KIND_SENSOR: begin
          if (it.sensor_level != level_seen) begin
            absent_seconds = '0;
            if (it.sensor_level) begin
              absence_on = 1'b0;
              if (!room_busy) begin
                room_busy = 1'b1;
                issue = 1'b1;
                code = CODE_OCCUPANCY;
              end
            end else begin
              absence_on = 1'b1;
            end
            level_seen = it.sensor_level;
          end
        end
        KIND_COMMAND: begin
          if (it.command_code == CMD_SET_REPLY || it.command_code == CMD_SET_SILENT) begin
            relays = {it.relay_four_request != 8'd0, it.relay_three_request != 8'd0,
                      it.relay_two_request != 8'd0, it.relay_one_request != 8'd0};
            if (it.new_delay_minutes != delay_min) begin
              delay_min = it.new_delay_minutes;
              saved = 1'b1;
            end
            if (it.command_code == CMD_SET_REPLY) begin
              issue = 1'b1;
              code = CODE_CMD_REPLY;
            end
          end else if (it.command_code == CMD_STATUS) begin
            issue = 1'b1;
            code = CODE_STATUS_REPLY;
          end
        end
        default: ;
      endcase
      if (issue) seconds_since_report = '0;
      r.report_valid = issue;
      r.report_code = issue ? code : '0;
      r.report_node = issue ? node_id : '0;
      r.relay_one_on = relays[0];
      r.relay_two_on = relays[1];
      r.relay_three_on = relays[2];
      r.relay_four_on = relays[3];
      r.sensor_now = level_seen;
      r.occupied = room_busy;
      r.delay_now = delay_min;
      r.save_delay = saved;
      status_queue.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
        fault_count++;
      end
    endfunction

    function void match_status(result_t seen);
      result_t want;
      if (status_queue.size() == 0) begin
        $display("%0t: result beat with none expected, expected none got %p", $time, seen);
        fault_count++;
        return;
      end
      want = status_queue.pop_front();
      compare_field("report_valid", 32'(want.report_valid), 32'(seen.report_valid));
      compare_field("report_code", 32'(want.report_code), 32'(seen.report_code));
      compare_field("report_node", 32'(want.report_node), 32'(seen.report_node));
      compare_field("relay_one_on", 32'(want.relay_one_on), 32'(seen.relay_one_on));
      compare_field("relay_two_on", 32'(want.relay_two_on), 32'(seen.relay_two_on));
      compare_field("relay_three_on", 32'(want.relay_three_on), 32'(seen.relay_three_on));
      compare_field("relay_four_on", 32'(want.relay_four_on), 32'(seen.relay_four_on));
      compare_field("sensor_now", 32'(want.sensor_now), 32'(seen.sensor_now));
      compare_field("occupied", 32'(want.occupied), 32'(seen.occupied));
      compare_field("delay_now", 32'(want.delay_now), 32'(seen.delay_now));
      compare_field("save_delay", 32'(want.save_delay), 32'(seen.save_delay));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  orn_in_if  in_ch();
  orn_out_if out_ch();

  relay_node_board board = new();
  int unsigned     cycle_count = 0;
  bit              hold_off_request = 1'b0;
  int              send_run = 0;
  bit              send_eager = 1'b0;

  occupancy_relay_node_controller_top DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin : beat_monitor
    item_t   seen_item;
    result_t seen_status;
    if (!rst && in_ch.valid && in_ch.ready) begin
      seen_item.kind = in_ch.kind;
      seen_item.sensor_level = in_ch.sensor_level;
      seen_item.command_code = in_ch.command_code;
      seen_item.relay_one_request = in_ch.relay_one_request;
      seen_item.relay_two_request = in_ch.relay_two_request;
      seen_item.relay_three_request = in_ch.relay_three_request;
      seen_item.relay_four_request = in_ch.relay_four_request;
      seen_item.new_delay_minutes = in_ch.new_delay_minutes;
      board.take_item(seen_item);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen_status.report_valid = out_ch.report_valid;
      seen_status.report_code = out_ch.report_code;
      seen_status.report_node = out_ch.report_node;
      seen_status.relay_one_on = out_ch.relay_one_on;
      seen_status.relay_two_on = out_ch.relay_two_on;
      seen_status.relay_three_on = out_ch.relay_three_on;
      seen_status.relay_four_on = out_ch.relay_four_on;
      seen_status.sensor_now = out_ch.sensor_now;
      seen_status.occupied = out_ch.occupied;
      seen_status.delay_now = out_ch.delay_now;
      seen_status.save_delay = out_ch.save_delay;
      board.match_status(seen_status);
    end
  end

  function automatic int draw_gap(inout int run_left, inout bit eager);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 40);
      eager = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return eager ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic logic [7:0] relay_request();
    return $urandom_range(0, 1) ? 8'($urandom) : 8'd0;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    it.kind = pick < 55 ? KIND_TICK : pick < 75 ? KIND_SENSOR :
              pick < 96 ? KIND_COMMAND : KIND_UNUSED;
    it.sensor_level = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    it.command_code = pick < 30 ? CMD_SET_REPLY : pick < 55 ? CMD_SET_SILENT :
                      pick < 85 ? CMD_STATUS : 8'($urandom);
    it.relay_one_request = relay_request();
    it.relay_two_request = relay_request();
    it.relay_three_request = relay_request();
    it.relay_four_request = relay_request();
    it.new_delay_minutes = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    return it;
  endfunction

  function automatic item_t make_item(logic [1:0] kind, logic level, logic [7:0] cmd,
                                      logic [7:0] r1, logic [7:0] r2, logic [7:0] r3,
                                      logic [7:0] r4, logic [7:0] delay_req);
    item_t it;
    it.kind = kind;
    it.sensor_level = level;
    it.command_code = cmd;
    it.relay_one_request = r1;
    it.relay_two_request = r2;
    it.relay_three_request = r3;
    it.relay_four_request = r4;
    it.new_delay_minutes = delay_req;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = draw_gap(send_run, send_eager);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.sensor_level <= it.sensor_level;
    in_ch.command_code <= it.command_code;
    in_ch.relay_one_request <= it.relay_one_request;
    in_ch.relay_two_request <= it.relay_two_request;
    in_ch.relay_three_request <= it.relay_three_request;
    in_ch.relay_four_request <= it.relay_four_request;
    in_ch.new_delay_minutes <= it.new_delay_minutes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.status_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.write_register(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] node, input logic [9:0] period,
                           input logic [6:0] tps, input logic [7:0] delay_init);
    settle();
    write_register(REG_NODE_ID, 32'(node));
    write_register(REG_REPORT_PERIOD, 32'(period));
    write_register(REG_TICKS_PER_SEC, 32'(tps));
    write_register(REG_INIT_DELAY, 32'(delay_init));
  endtask

  task automatic run_phase(input logic [7:0] node, input logic [9:0] period,
                           input logic [6:0] tps, input logic [7:0] delay_init,
                           input int beats, input bit long_hold);
    int    counted;
    int    run_len;
    item_t it;
    configure(node, period, tps, delay_init);
    counted = 0;
    if (long_hold) hold_off_request = 1'b1;
    while (counted < beats) begin
      if ($urandom_range(0, 3) == 0) begin
        it = random_item();
        it.kind = KIND_SENSOR;
        it.sensor_level = 1'b0;
        send_item(it);
        counted++;
        run_len = $urandom_range(1, 20);
        repeat (run_len) begin
          it = random_item();
          it.kind = KIND_TICK;
          send_item(it);
          counted++;
        end
      end else begin
        it = random_item();
        send_item(it);
        if (it.kind != KIND_UNUSED &&
            !(it.kind == KIND_COMMAND && it.command_code != CMD_SET_REPLY &&
              it.command_code != CMD_SET_SILENT && it.command_code != CMD_STATUS))
          counted++;
      end
    end
  endtask

  initial begin : status_sink
    int gap;
    int held;
    int recv_run;
    bit recv_eager;
    recv_run = 0;
    recv_eager = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ch.ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
      end else begin
        gap = draw_gap(recv_run, recv_eager);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.sensor_level <= 1'b0;
    in_ch.command_code <= '0;
    in_ch.relay_one_request <= '0;
    in_ch.relay_two_request <= '0;
    in_ch.relay_three_request <= '0;
    in_ch.relay_four_request <= '0;
    in_ch.new_delay_minutes <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    configure(8'd0, 10'd1, 7'd1, 8'd0);
    send_item(make_item(KIND_COMMAND, 1'b0, CMD_STATUS, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_SENSOR, 1'b1, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_SENSOR, 1'b1, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_TICK, 1'b0, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_SENSOR, 1'b0, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_TICK, 1'b0, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_COMMAND, 1'b0, CMD_SET_REPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0));
    send_item(make_item(KIND_COMMAND, 1'b1, CMD_SET_REPLY, 8'h01, 8'h00, 8'h80, 8'h00, 8'hFF));
    send_item(make_item(KIND_COMMAND, 1'b0, CMD_SET_SILENT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(KIND_COMMAND, 1'b0, CMD_SET_SILENT, 8'h00, 8'h7F, 8'h00, 8'hFE, 8'h00));
    send_item(make_item(KIND_COMMAND, 1'b0, CMD_UNKNOWN_LOW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(KIND_COMMAND, 1'b1, CMD_UNKNOWN_HIGH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(KIND_COMMAND, 1'b0, CMD_UNKNOWN_NEAR, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h05));
    send_item(make_item(KIND_UNUSED, 1'b1, CMD_SET_REPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(KIND_SENSOR, 1'b1, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_SENSOR, 1'b0, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_TICK, 1'b0, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_SENSOR, 1'b1, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_SENSOR, 1'b0, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_SENSOR, 1'b1, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_TICK, 1'b0, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(KIND_TICK, 1'b1, CMD_UNKNOWN_LOW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

    run_phase(8'd255, 10'd3, 7'd2, 8'd1, 120, 1'b0);
    run_phase(8'd17, 10'd1023, 7'd1, 8'd0, 100, 1'b0);
    run_phase(8'd200, 10'd1, 7'd127, 8'd2, 80, 1'b0);
    run_phase(8'd99, 10'd0, 7'd0, 8'd0, 100, 1'b0);
    run_phase(8'd128, 10'd5, 7'd3, 8'd255, 100, 1'b0);
    run_phase(8'd1, 10'd2, 7'd1, 8'd1, 150, 1'b1);
    run_phase(8'd52, 10'd4, 7'd1, 8'd0, 150, 1'b0);
    settle();

    if (board.fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ occupancy_relay_node_controller_top.f @@
design/orn_pkg.sv
design/orn_if.sv
design/orn_cfg.sv
design/orn_in_stage.sv
design/orn_engine.sv
design/occupancy_relay_node_controller_top.sv
design/orn_checker.sv
tb/sv/testbench.sv
